/* design/tgq_pkg.sv */
// Shared constants, types and fixed-point helpers for the text glyph quad generator.
package tgq_pkg;

   localparam int GLYPHS       = 96;
   localparam int GLYPH_HEIGHT = 16;
   localparam int FRAC_BITS    = 24;

   localparam int CFG_FRAC = 24;
   localparam int UP_SH    = (FRAC_BITS >= CFG_FRAC) ? (FRAC_BITS - CFG_FRAC) : 0;
   localparam int DN_SH    = (FRAC_BITS < CFG_FRAC) ? (CFG_FRAC - FRAC_BITS) : 0;
   localparam int SLOT_W   = (GLYPHS > 1) ? $clog2(GLYPHS) : 1;

   localparam int CFG_W     = 25;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_HALF_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INV_HALF_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CFG_W-1:0] INV_HALF_WIDTH_RESET  = 25'd52429;
   localparam logic [CFG_W-1:0] INV_HALF_HEIGHT_RESET = 25'd69905;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_DRAW  = 2'd2;

   localparam logic [7:0] SPACE_CODE    = 8'd32;
   localparam int         SPACE_ADVANCE = 3;

   localparam int OPA_W  = 17;
   localparam int PROD_W = 43;
   localparam int WIDE_W = 48;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   localparam int VTX_W = 3;
   localparam logic [VTX_W-1:0] VTX_TL0 = 3'd0;
   localparam logic [VTX_W-1:0] VTX_BR0 = 3'd1;
   localparam logic [VTX_W-1:0] VTX_BL  = 3'd2;
   localparam logic [VTX_W-1:0] VTX_TL1 = 3'd3;
   localparam logic [VTX_W-1:0] VTX_TR  = 3'd4;
   localparam logic [VTX_W-1:0] VTX_BR1 = 3'd5;

   localparam logic signed [WIDE_W-1:0] RND_HALF = WIDE_W'((64'd1 << DN_SH) >> 1);
   localparam logic signed [WIDE_W-1:0] ONE_WIDE = WIDE_W'(64'd1 << FRAC_BITS);
   localparam logic signed [31:0]       PEN_ONE  = 32'(64'd1 << FRAC_BITS);
   localparam logic signed [WIDE_W-1:0] S32_MAX  = {{(WIDE_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [WIDE_W-1:0] S32_MIN  = {{(WIDE_W-31){1'b1}}, {31{1'b0}}};

   typedef struct packed {
      logic [1:0]         req_type;
      logic [6:0]         glyph_slot;
      logic [16:0]        tex_left;
      logic [16:0]        tex_right;
      logic [7:0]         glyph_pixels;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic [7:0]         char_code;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic [16:0]        tex_u;
      logic               tex_v;
      logic               last_vertex;
   } rsp_item_type;

   typedef struct packed {
      logic [16:0] left;
      logic [16:0] right;
      logic [7:0]  width;
   } glyph_type;

   typedef enum logic [1:0] {CMD_START, CMD_SPACE, CMD_DRAW} cmd_kind_type;

   // prod_a: x distance, prod_b: y distance, prod_c: pen advance after a glyph
   typedef struct packed {
      cmd_kind_type              kind;
      logic signed [PROD_W-1:0]  prod_a;
      logic signed [PROD_W-1:0]  prod_b;
      logic signed [PROD_W-1:0]  prod_c;
      logic [16:0]               tex_l;
      logic [16:0]               tex_r;
   } cmd_type;

   typedef struct packed {
      logic [CMD_CNT_W-1:0] count;
      logic                 avail;
   } fifo_status_type;

   // 24 fractional bits to FRAC_BITS, round half up when narrowing
   function automatic logic signed [WIDE_W-1:0] rescale(input logic signed [PROD_W-1:0] q);
      logic signed [WIDE_W-1:0] e;
      e = WIDE_W'(q);
      return ((e + RND_HALF) >>> DN_SH) <<< UP_SH;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      if (v > S32_MAX) begin
         return 32'sh7fffffff;
      end else if (v < S32_MIN) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

/* design/tgq_front.sv */
// Front end: config registers, glyph table, request classification and distance products.
module tgq_front
   import tgq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_item_type         req_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  fifo_status_type      cmd_status,
   output logic                 cmd_push,
   output cmd_type              cmd_data
);

   logic [CFG_W-1:0] inv_w_ff, inv_h_ff;
   glyph_type        glyph_mem [GLYPHS];
   glyph_type        glyph_rd_ff;

   logic             s1_valid_ff, s1_valid_in;
   cmd_kind_type     s1_kind_ff, s1_kind_in;
   logic signed [15:0] s1_sx_ff, s1_sy_ff;

   logic             s2_valid_ff;
   cmd_type          s2_cmd_ff, s2_cmd_in;

   logic             accept;
   logic [7:0]       slot_ext, code_off;
   logic             load_ok, glyph_ok, is_space;
   logic [CMD_CNT_W:0] in_flight;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_w_ff <= INV_HALF_WIDTH_RESET;
         inv_h_ff <= INV_HALF_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INV_HALF_WIDTH:  inv_w_ff <= csr_wdata;
            CSR_INV_HALF_HEIGHT: inv_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // credit check: everything in the two front stages is counted as a queue entry
   always_comb begin
      in_flight = {1'b0, cmd_status.count} + (CMD_CNT_W+1)'(s1_valid_ff)
                + (CMD_CNT_W+1)'(s2_valid_ff);
      req_full  = in_flight >= (CMD_CNT_W+1)'(CMD_DEPTH);
   end

   assign accept = req_push && !req_full;

   always_comb begin
      slot_ext = {1'b0, req_data.glyph_slot};
      code_off = req_data.char_code - SPACE_CODE;
      load_ok  = slot_ext < 8'(GLYPHS);
      is_space = req_data.char_code == SPACE_CODE;
      glyph_ok = (req_data.char_code > SPACE_CODE) && (code_off < 8'(GLYPHS));
      s1_valid_in = 1'b0;
      s1_kind_in  = CMD_DRAW;
      unique case (req_data.req_type)
         REQ_START: begin
            s1_valid_in = accept;
            s1_kind_in  = CMD_START;
         end
         REQ_DRAW: begin
            s1_valid_in = accept && (is_space || glyph_ok);
            s1_kind_in  = is_space ? CMD_SPACE : CMD_DRAW;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.req_type == REQ_LOAD && load_ok) begin
         glyph_mem[slot_ext[SLOT_W-1:0]] <= '{left: req_data.tex_left,
                                              right: req_data.tex_right,
                                              width: req_data.glyph_pixels};
      end
      if (accept) begin
         glyph_rd_ff <= glyph_mem[code_off[SLOT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= s1_kind_in;
         s1_sx_ff   <= req_data.start_x;
         s1_sy_ff   <= req_data.start_y;
      end
      if (s1_valid_ff) begin
         s2_cmd_ff <= s2_cmd_in;
      end
   end

   // operand select per command, then three parallel products
   always_comb begin
      logic signed [OPA_W-1:0]  opa, opb;
      logic signed [PROD_W-1:0] opa_x, opb_x, opc_x, iw_x, ih_x;
      opa = '0;
      opb = '0;
      unique case (s1_kind_ff)
         CMD_START: begin
            opa = OPA_W'(s1_sx_ff);
            opb = -OPA_W'(s1_sy_ff);
         end
         CMD_SPACE: begin
            opa = OPA_W'(SPACE_ADVANCE);
         end
         CMD_DRAW: begin
            opa = OPA_W'({1'b0, glyph_rd_ff.width});
            opb = OPA_W'(GLYPH_HEIGHT);
         end
         default: ;
      endcase
      opa_x = PROD_W'(opa);
      opb_x = PROD_W'(opb);
      opc_x = PROD_W'({1'b0, {1'b0, glyph_rd_ff.width} + 9'd1});
      iw_x  = PROD_W'({1'b0, inv_w_ff});
      ih_x  = PROD_W'({1'b0, inv_h_ff});
      s2_cmd_in.kind   = s1_kind_ff;
      s2_cmd_in.prod_a = opa_x * iw_x;
      s2_cmd_in.prod_b = opb_x * ih_x;
      s2_cmd_in.prod_c = opc_x * iw_x;
      s2_cmd_in.tex_l  = glyph_rd_ff.left;
      s2_cmd_in.tex_r  = glyph_rd_ff.right;
   end

   assign cmd_push = s2_valid_ff;
   assign cmd_data = s2_cmd_ff;

endmodule

/* design/tgq_cmd_fifo.sv */
// Short command queue between front end and vertex engine.
module tgq_cmd_fifo
   import tgq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cmd_type         push_data,
   input  logic            pop,
   output cmd_type         pop_data,
   output fifo_status_type status
);

   cmd_type              entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CMD_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.avail = count_ff != '0;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff < CMD_CNT_W'(CMD_DEPTH))
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("command queue underflow");

endmodule

/* design/tgq_back.sv */
// Vertex engine: pen state, command execution and the six-vertex quad sequencer.
module tgq_back
   import tgq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  fifo_status_type cmd_status,
   input  cmd_type         cmd_data,
   output logic            cmd_pop,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output rsp_item_type    rsp_data
);

   logic signed [31:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic signed [31:0] x0_ff, y0_ff, x1_ff, y1_ff, x1_in, y1_in;
   logic [16:0]        tl_ff, tr_ff;
   logic               busy_ff, busy_in;
   logic [VTX_W-1:0]   vtx_ff, vtx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_ff, vtx_item;
   logic               out_adv, emit, quad_done, draw_pop;

   assign out_adv   = !rsp_valid_ff || rsp_pop;
   assign emit      = busy_ff && out_adv;
   assign quad_done = emit && vtx_ff == VTX_BR1;
   assign cmd_pop   = cmd_status.avail && (!busy_ff || quad_done);
   assign draw_pop  = cmd_pop && cmd_data.kind == CMD_DRAW;

   always_comb begin
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      x1_in    = sat32(WIDE_W'(pen_x_ff) + rescale(cmd_data.prod_a));
      y1_in    = sat32(WIDE_W'(pen_y_ff) - rescale(cmd_data.prod_b));
      if (cmd_pop) begin
         unique case (cmd_data.kind)
            CMD_START: begin
               pen_x_in = sat32(rescale(cmd_data.prod_a) - ONE_WIDE);
               pen_y_in = sat32(rescale(cmd_data.prod_b) + ONE_WIDE);
            end
            CMD_SPACE: pen_x_in = x1_in;
            CMD_DRAW:  pen_x_in = sat32(WIDE_W'(pen_x_ff) + rescale(cmd_data.prod_c));
            default: ;
         endcase
      end
      busy_in      = draw_pop ? 1'b1 : (quad_done ? 1'b0 : busy_ff);
      vtx_in       = emit ? (quad_done ? VTX_TL0 : vtx_ff + 1'b1) : vtx_ff;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_pop);
   end

   // vertex order: two triangles TL-BR-BL and TL-TR-BR
   always_comb begin
      vtx_item = '{vert_x: x1_ff, vert_y: y1_ff, tex_u: tr_ff, tex_v: 1'b1,
                   last_vertex: 1'b0};
      unique case (vtx_ff)
         VTX_TL0, VTX_TL1: vtx_item = '{vert_x: x0_ff, vert_y: y0_ff, tex_u: tl_ff,
                                        tex_v: 1'b0, last_vertex: 1'b0};
         VTX_BR0: ;
         VTX_BL:  vtx_item = '{vert_x: x0_ff, vert_y: y1_ff, tex_u: tl_ff,
                               tex_v: 1'b1, last_vertex: 1'b0};
         VTX_TR:  vtx_item = '{vert_x: x1_ff, vert_y: y0_ff, tex_u: tr_ff,
                               tex_v: 1'b0, last_vertex: 1'b0};
         VTX_BR1: vtx_item.last_vertex = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= -PEN_ONE;
         pen_y_ff     <= PEN_ONE;
         busy_ff      <= 1'b0;
         vtx_ff       <= VTX_TL0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         busy_ff      <= busy_in;
         vtx_ff       <= vtx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (draw_pop) begin
         x0_ff <= pen_x_ff;
         y0_ff <= pen_y_ff;
         x1_ff <= x1_in;
         y1_ff <= y1_in;
         tl_ff <= cmd_data.tex_l;
         tr_ff <= cmd_data.tex_r;
      end
      if (emit) begin
         rsp_ff <= vtx_item;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_vtx_range: assert property (@(posedge clock) disable iff (reset)
      vtx_ff <= VTX_BR1)
      else $error("vertex counter out of range");

   a_last_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pop && rsp_ff.last_vertex |=> !rsp_valid_ff || !rsp_ff.last_vertex)
      else $error("two quad ends in a row");

endmodule

/* design/text_glyph_quad_generator.sv */
// Top level of the text glyph quad generator: front end, command queue, vertex engine.
//
//  port group | direction | handshake            | payload
//  req_       | in        | push / full          | req_item_type (load, start, draw)
//  rsp_       | out       | pop / empty          | rsp_item_type (one vertex)
//  csr_       | in        | we, index            | wdata, 25 bits, no read-back
//
// A drawn glyph produces six vertices, one per cycle while the receiver keeps popping, and
// the next queued glyph starts as the last vertex of a quad goes out.
// Loads, starts, spaces and ignored codes produce no vertices; a request reaches the vertex
// engine through the table read, the product stage and the queue, in that order.
// full rises when four commands are in flight; output stalls back up through the queue.
// Reset is synchronous; the glyph table holds no reset state and must be loaded first.
module text_glyph_quad_generator
   import tgq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_item_type         req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_item_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   fifo_status_type cmd_status;
   logic            cmd_push, cmd_pop;
   cmd_type         cmd_in, cmd_out;

   tgq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_status (cmd_status),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_in)
   );

   tgq_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .status    (cmd_status)
   );

   tgq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_status (cmd_status),
      .cmd_data   (cmd_out),
      .cmd_pop    (cmd_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

/* sim/tb_text_glyph_quad_generator.sv */
// Self-checking testbench for the text glyph quad generator: glyph loads, strings, quads.
module tb_text_glyph_quad_generator
   import tgq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     TIMEOUT_NS    = 2_000_000;
   localparam int     SETTLE_CYCLES = 16;
   localparam int     HOLD_CYCLES   = 150;
   localparam int     MAX_GAP       = 8;
   localparam int     RANDOM_ITEMS  = 38;
   localparam longint PEN_MAX       = 64'sd2147483647;
   localparam longint PEN_MIN       = -64'sd2147483648;

   localparam logic [1:0]           REQ_NONE     = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3  = CSR_IDX_W'(3);
   localparam logic [CFG_W-1:0]     INV_MIN      = 25'd1;
   localparam logic [CFG_W-1:0]     INV_MAX      = 25'd16777216;
   localparam logic [CFG_W-1:0]     INV_ALL_ONES = '1;

   typedef enum int {SINK_ALWAYS, SINK_COIN, SINK_QUARTER, SINK_MOSTLY} sink_mode_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   req_item_type         req_data;
   logic                 rsp_empty;
   logic                 rsp_pop;
   rsp_item_type         rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   // predictor state
   logic [16:0]        glyph_left  [GLYPHS];
   logic [16:0]        glyph_right [GLYPHS];
   logic [7:0]         glyph_width [GLYPHS];
   bit                 glyph_loaded[GLYPHS];
   int                 loaded_slots[$];
   logic signed [31:0] pen_x_fx;
   logic signed [31:0] pen_y_fx;
   logic [CFG_W-1:0]   scale_x;
   logic [CFG_W-1:0]   scale_y;
   rsp_item_type       vertex_q[$];

   int errors        = 0;
   int items_sent    = 0;
   int burst_left    = 0;
   int hold_requests = 0;

   text_glyph_quad_generator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // pixel product (24 fractional bits) to pen units
   function automatic longint to_pen_units(longint q);
      if (UP_SH > 0) begin
         return q <<< UP_SH;
      end
      return (q + ((longint'(1) <<< DN_SH) >>> 1)) >>> DN_SH;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > PEN_MAX) begin
         return 32'sh7fffffff;
      end
      if (v < PEN_MIN) begin
         return 32'sh80000000;
      end
      return 32'(v);
   endfunction

   function automatic void push_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                       logic [16:0] u, logic v, logic last);
      rsp_item_type vx;
      vx.vert_x      = x;
      vx.vert_y      = y;
      vx.tex_u       = u;
      vx.tex_v       = v;
      vx.last_vertex = last;
      vertex_q.push_back(vx);
   endfunction

   function automatic void reset_predictor();
      foreach (glyph_loaded[i]) begin
         glyph_left[i]   = '0;
         glyph_right[i]  = '0;
         glyph_width[i]  = '0;
         glyph_loaded[i] = 1'b0;
      end
      loaded_slots.delete();
      pen_x_fx = clamp32(-(longint'(1) <<< FRAC_BITS));
      pen_y_fx = clamp32(longint'(1) <<< FRAC_BITS);
      scale_x  = INV_HALF_WIDTH_RESET;
      scale_y  = INV_HALF_HEIGHT_RESET;
   endfunction

   // updates the pen and glyph table for one accepted transaction, queues its vertices
   function automatic void predict_vertices(req_item_type it);
      longint             iw;
      longint             ih;
      longint             one;
      longint             w;
      int                 slot;
      int                 code;
      logic signed [31:0] x1;
      logic signed [31:0] y1;
      iw   = longint'(scale_x);
      ih   = longint'(scale_y);
      one  = longint'(1) <<< FRAC_BITS;
      code = int'(it.char_code);
      case (it.req_type)
         REQ_LOAD: begin
            slot = int'(it.glyph_slot);
            if (slot < GLYPHS) begin
               glyph_left[slot]  = it.tex_left;
               glyph_right[slot] = it.tex_right;
               glyph_width[slot] = it.glyph_pixels;
               if (!glyph_loaded[slot]) begin
                  glyph_loaded[slot] = 1'b1;
                  loaded_slots.push_back(slot);
               end
            end
         end
         REQ_START: begin
            pen_x_fx = clamp32(to_pen_units(longint'($signed(it.start_x)) * iw) - one);
            pen_y_fx = clamp32(to_pen_units(-longint'($signed(it.start_y)) * ih) + one);
         end
         REQ_DRAW: begin
            if (code == int'(SPACE_CODE)) begin
               pen_x_fx = clamp32(longint'(pen_x_fx) + to_pen_units(SPACE_ADVANCE * iw));
            end else if (code > int'(SPACE_CODE) && code - int'(SPACE_CODE) < GLYPHS) begin
               slot = code - int'(SPACE_CODE);
               w  = longint'(glyph_width[slot]);
               x1 = clamp32(longint'(pen_x_fx) + to_pen_units(w * iw));
               y1 = clamp32(longint'(pen_y_fx) - to_pen_units(longint'(GLYPH_HEIGHT) * ih));
               push_vertex(pen_x_fx, pen_y_fx, glyph_left[slot],  1'b0, 1'b0);
               push_vertex(x1,       y1,       glyph_right[slot], 1'b1, 1'b0);
               push_vertex(pen_x_fx, y1,       glyph_left[slot],  1'b1, 1'b0);
               push_vertex(pen_x_fx, pen_y_fx, glyph_left[slot],  1'b0, 1'b0);
               push_vertex(x1,       pen_y_fx, glyph_right[slot], 1'b0, 1'b0);
               push_vertex(x1,       y1,       glyph_right[slot], 1'b1, 1'b1);
               pen_x_fx = clamp32(longint'(pen_x_fx) + to_pen_units((w + 1) * iw));
            end
         end
         default: ;
      endcase
   endfunction

   function automatic req_item_type rand_item(logic [1:0] kind);
      req_item_type it;
      it.req_type     = kind;
      it.glyph_slot   = 7'($urandom);
      it.tex_left     = 17'($urandom);
      it.tex_right    = 17'($urandom);
      it.glyph_pixels = 8'($urandom);
      it.start_x      = 16'($urandom);
      it.start_y      = 16'($urandom);
      it.char_code    = 8'($urandom);
      return it;
   endfunction

   function automatic req_item_type make_load(logic [6:0] slot, logic [16:0] left,
                                              logic [16:0] right, logic [7:0] pixels);
      req_item_type it;
      it = rand_item(REQ_LOAD);
      it.glyph_slot   = slot;
      it.tex_left     = left;
      it.tex_right    = right;
      it.glyph_pixels = pixels;
      return it;
   endfunction

   function automatic req_item_type make_start(logic signed [15:0] x, logic signed [15:0] y);
      req_item_type it;
      it = rand_item(REQ_START);
      it.start_x = x;
      it.start_y = y;
      return it;
   endfunction

   function automatic req_item_type make_draw(logic [7:0] code);
      req_item_type it;
      it = rand_item(REQ_DRAW);
      it.char_code = code;
      return it;
   endfunction

   // mostly loaded glyphs, some spaces, some codes outside the table
   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12 || loaded_slots.size() == 0) begin
         return SPACE_CODE;
      end
      if (r < 22) begin
         return ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 31))
                                            : 8'($urandom_range(GLYPHS + 32, 255));
      end
      return 8'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]) + SPACE_CODE;
   endfunction

   // one input transaction; returns right after the accepting edge
   task automatic send_item(req_item_type it);
      @(negedge clock);
      if (burst_left == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
      end
      burst_left--;
      req_push <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_vertices(it);
      items_sent++;
   endtask

   // stop sending and wait for the block to go idle
   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (vertex_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_INV_HALF_WIDTH) begin
         scale_x = value;
      end else if (idx == CSR_INV_HALF_HEIGHT) begin
         scale_y = value;
      end
   endtask

   task automatic test_directed();
      send_item(make_load(7'd33, 17'd0, 17'd65536, 8'd8));
      send_item(make_load(7'd0, 17'd100, 17'd200, 8'd5));
      send_item(make_load(7'd95, 17'h1ffff, 17'd0, 8'd255));
      send_item(make_load(7'd64, 17'd12345, 17'd23456, 8'd0));
      send_item(make_load(7'd96, 17'd1, 17'd1, 8'd1));
      send_item(make_load(7'd127, 17'd2, 17'd2, 8'd2));
      // pen still at its reset position
      send_item(make_draw(8'd65));
      send_item(make_draw(8'd127));
      send_item(make_draw(8'd96));
      send_item(make_draw(SPACE_CODE));
      send_item(make_draw(8'd0));
      send_item(make_draw(8'd31));
      send_item(make_draw(8'd128));
      send_item(make_draw(8'd255));
      send_item(rand_item(REQ_NONE));
      send_item(make_start(16'sd0, 16'sd0));
      send_item(make_draw(8'd65));
      send_item(make_start(16'sd32767, -16'sd32768));
      send_item(make_draw(8'd127));
      send_item(make_start(-16'sd32768, 16'sd32767));
      send_item(make_draw(8'd65));
      send_item(make_draw(SPACE_CODE));
   endtask

   task automatic test_config_extremes();
      settle();
      write_csr(CSR_INV_HALF_WIDTH, INV_MAX);
      write_csr(CSR_INV_HALF_HEIGHT, INV_MAX);
      send_item(make_start(16'sd32767, 16'sd32767));
      send_item(make_draw(8'd127));
      send_item(make_draw(SPACE_CODE));
      send_item(make_draw(8'd65));
      send_item(make_start(-16'sd32768, -16'sd32768));
      send_item(make_draw(8'd127));
      send_item(make_draw(8'd96));
      settle();
      write_csr(CSR_INV_HALF_WIDTH, INV_ALL_ONES);
      write_csr(CSR_INV_HALF_HEIGHT, INV_ALL_ONES);
      send_item(make_start(16'sd32767, -16'sd32768));
      send_item(make_draw(8'd127));
      send_item(make_draw(SPACE_CODE));
      send_item(make_start(-16'sd32768, 16'sd32767));
      send_item(make_draw(8'd65));
      settle();
      write_csr(CSR_INV_HALF_WIDTH, INV_MIN);
      write_csr(CSR_INV_HALF_HEIGHT, INV_MIN);
      send_item(make_start(16'sd100, 16'sd100));
      send_item(make_draw(8'd65));
      send_item(make_draw(8'd127));
      settle();
      write_csr(CSR_INV_HALF_WIDTH, '0);
      write_csr(CSR_INV_HALF_HEIGHT, '0);
      send_item(make_start(16'sd5, 16'sd5));
      send_item(make_draw(8'd65));
      settle();
      // writes outside the register list must leave the scales alone
      write_csr(CSR_SPARE_2, CFG_W'($urandom));
      write_csr(CSR_SPARE_3, CFG_W'($urandom));
      send_item(make_draw(8'd65));
      settle();
      write_csr(CSR_INV_HALF_WIDTH, INV_HALF_WIDTH_RESET);
      write_csr(CSR_INV_HALF_HEIGHT, INV_HALF_HEIGHT_RESET);
      send_item(make_draw(8'd65));
   endtask

   // receiver holds off while glyphs keep coming, so the input side has to stall
   task automatic test_backpressure();
      int k;
      settle();
      hold_requests++;
      send_item(make_start(16'sd20, 16'sd40));
      for (k = 0; k < 24; k++) begin
         send_item(make_draw(pick_char()));
      end
   endtask

   task automatic send_text_run();
      int n;
      int k;
      n = $urandom_range(0, 2);
      for (k = 0; k < n; k++) begin
         send_item(make_load(($urandom_range(0, 7) == 0) ? 7'($urandom_range(GLYPHS, 127))
                                                         : 7'($urandom_range(0, GLYPHS - 1)),
                             17'($urandom), 17'($urandom), 8'($urandom)));
      end
      if ($urandom_range(0, 3) == 0) begin
         send_item(make_start(16'($urandom), 16'($urandom)));
      end else begin
         send_item(make_start(16'(int'($urandom_range(0, 660)) - 10),
                              16'(int'($urandom_range(0, 500)) - 10)));
      end
      n = $urandom_range(3, 9);
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 11) == 0) begin
            send_item(rand_item(REQ_NONE));
         end else begin
            send_item(make_draw(pick_char()));
         end
      end
   endtask

   task automatic test_random_text();
      int phase;
      int phase_end;
      for (phase = 0; phase < 4; phase++) begin
         settle();
         case (phase)
            0: begin
               write_csr(CSR_INV_HALF_WIDTH, INV_MAX);
               write_csr(CSR_INV_HALF_HEIGHT, CFG_W'($urandom_range(1, 16777216)));
            end
            1: begin
               write_csr(CSR_INV_HALF_WIDTH, CFG_W'($urandom_range(1, 16777216)));
               write_csr(CSR_INV_HALF_HEIGHT, CFG_W'($urandom_range(1, 16777216)));
            end
            2: begin
               write_csr(CSR_INV_HALF_WIDTH, INV_MIN);
               write_csr(CSR_INV_HALF_HEIGHT, INV_MAX);
            end
            default: begin
               write_csr(CSR_INV_HALF_WIDTH, INV_HALF_WIDTH_RESET);
               write_csr(CSR_INV_HALF_HEIGHT, INV_HALF_HEIGHT_RESET);
            end
         endcase
         phase_end = items_sent + RANDOM_ITEMS;
         while (items_sent < phase_end) send_text_run();
      end
   endtask

   // result side: pop pattern changes at random intervals, long hold on request
   initial begin : vertex_sink
      sink_mode_type mode;
      int            mode_left;
      int            hold_left;
      int            hold_seen;
      int            tick;
      rsp_pop   = 1'b0;
      mode      = SINK_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      hold_seen = 0;
      tick      = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = sink_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (mode)
               SINK_ALWAYS:  rsp_pop <= 1'b1;
               SINK_COIN:    rsp_pop <= 1'($urandom_range(0, 1));
               SINK_QUARTER: rsp_pop <= (tick % 4 == 0);
               default:      rsp_pop <= ($urandom_range(0, 9) < 7);
            endcase
         end
      end
   end

   function automatic int field_diff(string name, logic signed [32:0] exp_val,
                                     logic signed [32:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : vertex_check
      rsp_item_type exp_v;
      int           bad;
      if (!reset && rsp_empty === 1'b0 && rsp_pop) begin
         if (vertex_q.size() == 0) begin
            $display("%0t: unexpected vertex transaction, expected none actual x=%0d y=%0d",
                     $time, rsp_data.vert_x, rsp_data.vert_y);
            errors++;
         end else begin
            exp_v = vertex_q.pop_front();
            bad   = field_diff("vert_x", exp_v.vert_x, rsp_data.vert_x)
                  + field_diff("vert_y", exp_v.vert_y, rsp_data.vert_y)
                  + field_diff("tex_u", exp_v.tex_u, rsp_data.tex_u)
                  + field_diff("tex_v", exp_v.tex_v, rsp_data.tex_v)
                  + field_diff("last_vertex", exp_v.last_vertex, rsp_data.last_vertex);
            if (bad != 0) begin
               errors++;
            end
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("tb_text_glyph_quad_generator: errors");
      $finish;
   end

   initial begin : run_tests
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset_predictor();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_extremes();
      test_backpressure();
      test_random_text();
      settle();
      if (errors == 0) begin
         $display("tb_text_glyph_quad_generator: clean");
      end else begin
         $display("tb_text_glyph_quad_generator: errors");
      end
      $finish;
   end

endmodule

/* text_glyph_quad_generator.f */
design/tgq_pkg.sv
design/tgq_front.sv
design/tgq_cmd_fifo.sv
design/tgq_back.sv
design/text_glyph_quad_generator.sv
sim/tb_text_glyph_quad_generator.sv
